// ----- design/psdc_pkg.sv -----
package psdc_pkg;

    localparam int SAMPLE_W = 32;
    localparam int PREFIX_W = 48;
    localparam int COUNT_W  = 11;
    localparam int TOTAL_W  = 32;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [PREFIX_W-1:0] t_prefix;
    typedef logic        [TOTAL_W-1:0]  t_total;

endpackage

// ----- design/psdc_ram.sv -----
module psdc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/psdc_cmp.sv -----
module psdc_cmp (
    input  psdc_pkg::t_prefix i_stored,
    input  psdc_pkg::t_prefix i_prefix,
    output logic              o_le
);

    import psdc_pkg::*;

    // signed 48-bit order: stored entry at or below the new prefix
    assign o_le = (i_stored <= i_prefix);

endmodule

// ----- design/prefix_sum_dominance_counter.sv -----
// The o_valid strobe follows start after the prefix add, a walk over the prefix
// store at one entry per cycle through a single RAM read port and one shared
// comparator, and a final compare against the fixed zero entry.
// One item at a time; busy is high until the result is issued, no receiver stall.
// Reset (synchronous, active low) clears offset_k, prefix and total and sets the
// entry count to one, so that only the fixed zero entry is stored.
module prefix_sum_dominance_counter #(
    parameter int STORE_DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     i_cfg_we,
    input  logic [31:0]              i_cfg_wdata,
    input  psdc_pkg::t_sample        i_sample,
    input  logic                     i_first,
    output logic                     o_valid,
    output logic [10:0]              o_pair_count,
    output psdc_pkg::t_total         o_running_total,
    output logic                     o_store_full
);

    import psdc_pkg::*;

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CW = $clog2(STORE_DEPTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ADD  = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [SAMPLE_W-1:0] r_offset_k;
    logic [SAMPLE_W:0]   r_diff;
    t_prefix             r_prefix;
    t_total              r_total;
    logic [CW-1:0]       r_entry_n;
    logic [CW-1:0]       r_addr;
    logic [CW-1:0]       r_cnt;
    logic                r_pend;
    logic                r_valid;
    logic [COUNT_W-1:0]  r_pair_count;
    logic                r_full;

    logic                accept;
    logic                issue;
    logic                le;
    t_prefix             rd_data;
    t_prefix             cmp_b;
    logic [CW-1:0]       cnt_final;
    logic [TOTAL_W:0]    sum;
    logic                full;
    logic [CW+COUNT_W-1:0] cnt_ext;

    assign accept    = start && (r_state == ST_IDLE);
    assign issue     = (r_state == ST_SCAN) && (r_addr < r_entry_n);
    assign full      = (r_entry_n == CW'(STORE_DEPTH));
    assign cmp_b     = (r_state == ST_FIN) ? '0 : rd_data;
    assign cnt_final = r_cnt + CW'(le);
    assign sum       = {1'b0, r_total} + (TOTAL_W + 1)'(cnt_final);
    assign cnt_ext   = {{COUNT_W{1'b0}}, cnt_final};

    psdc_ram #(
        .WIDTH (PREFIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    ((r_state == ST_FIN) && !full),
        .i_waddr (r_entry_n[AW-1:0]),
        .i_wdata (r_prefix),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (rd_data)
    );

    // shared comparator: stored entries during the walk, the fixed zero
    // entry in the final step
    psdc_cmp u_cmp (
        .i_stored (cmp_b),
        .i_prefix (r_prefix),
        .o_le     (le)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD:  n_state = ST_SCAN;
            ST_SCAN: begin
                if (!issue && !r_pend) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_offset_k <= '0;
            r_prefix   <= '0;
            r_total    <= '0;
            r_entry_n  <= CW'(1);
            r_pend     <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == ST_FIN);
            r_pend  <= issue;
            if (i_cfg_we) begin
                r_offset_k <= i_cfg_wdata;
            end
            if (accept) begin
                r_diff <= {i_sample[SAMPLE_W-1], i_sample}
                        - {r_offset_k[SAMPLE_W-1], r_offset_k};
                // restart: only the fixed zero entry remains
                if (i_first) begin
                    r_prefix  <= '0;
                    r_total   <= '0;
                    r_entry_n <= CW'(1);
                end
            end
            if (r_state == ST_ADD) begin
                r_prefix <= r_prefix + {{(PREFIX_W-SAMPLE_W-1){r_diff[SAMPLE_W]}}, r_diff};
                r_cnt    <= '0;
                r_addr   <= CW'(1);
            end
            if (issue) begin
                r_addr <= r_addr + CW'(1);
            end
            if (r_pend && (r_state == ST_SCAN)) begin
                r_cnt <= cnt_final;
            end
            if (r_state == ST_FIN) begin
                r_total      <= sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
                r_pair_count <= cnt_ext[COUNT_W-1:0];
                r_full       <= full;
                if (!full) begin
                    r_entry_n <= r_entry_n + CW'(1);
                end
            end
        end
    end

    assign busy            = (r_state != ST_IDLE);
    assign o_valid         = r_valid;
    assign o_pair_count    = r_pair_count;
    assign o_running_total = r_total;
    assign o_store_full    = r_full;

endmodule
